@@ hdl/tsme_pkg.sv @@
// Shared types, codes and default sizes for the tape stack machine execute unit.
package tsme_pkg;

    localparam int TAPE_DEPTH_DEF  = 4096;
    localparam int STACK_DEPTH_DEF = 256;
    localparam int CELL_WIDTH_DEF  = 8;

    localparam int CFG_W  = 13;
    localparam int ARG_W  = 16;
    localparam int PC_W   = 16;
    localparam int BYTE_W = 8;

    localparam logic [CFG_W-1:0] TAPE_LENGTH_RST = CFG_W'(4096);

    typedef enum logic [3:0] {
        ACT_HALT    = 4'd0,
        ACT_ADD     = 4'd1,
        ACT_NOP     = 4'd2,
        ACT_SET     = 4'd3,
        ACT_POP     = 4'd4,
        ACT_PUSH    = 4'd5,
        ACT_PUSHIMM = 4'd6,
        ACT_MOVE    = 4'd7,
        ACT_SETPTR  = 4'd8,
        ACT_JMP     = 4'd9,
        ACT_JEZ     = 4'd10,
        ACT_JNZ     = 4'd11,
        ACT_JSEZ    = 4'd12,
        ACT_JSNZ    = 4'd13,
        ACT_IO      = 4'd14,
        ACT_INVALID = 4'd15
    } t_action;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_INVALID   = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } t_err;

    localparam logic [ARG_W-1:0] IO_IN_CELL  = ARG_W'(0);
    localparam logic [ARG_W-1:0] IO_OUT_CELL = ARG_W'(1);
    localparam logic [ARG_W-1:0] IO_IN_PUSH  = ARG_W'(2);
    localparam logic [ARG_W-1:0] IO_OUT_POP  = ARG_W'(3);

    typedef enum logic [1:0] {
        REM_IDLE = 2'd0,
        REM_RUN  = 2'd1,
        REM_DONE = 2'd2
    } t_rem_state;

endpackage

@@ hdl/tsme_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with same-edge write bypass.
module tsme_ram #(
    parameter int DEPTH = tsme_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = tsme_pkg::CELL_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_byp_data;
    logic             r_byp_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q        <= r_mem[i_raddr];
        r_byp_data <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_byp_hit ? r_byp_data : r_q;

endmodule

@@ hdl/tsme_rem.sv @@
// Bit-serial remainder unit for pointer reduction modulo the tape length.
module tsme_rem #(
    parameter int MAG_W = 17,
    parameter int LEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_mag,
    input  logic             i_neg,
    input  logic [LEN_W-1:0] i_len,
    input  logic             i_ack,
    output logic             o_done,
    output logic [LEN_W-1:0] o_rem
);

    localparam int STEP_W = $clog2(MAG_W + 1);

    tsme_pkg::t_rem_state r_state, n_state;

    logic [MAG_W-1:0]  r_mag;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_len;
    logic              r_neg;
    logic [STEP_W-1:0] r_step;

    logic              load;
    logic              run;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    trial_sub;
    logic [LEN_W-1:0]  rem_step;
    logic              last_step;

    assign last_step = (r_step == STEP_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsme_pkg::REM_IDLE: if (i_start) n_state = tsme_pkg::REM_RUN;
            tsme_pkg::REM_RUN:  if (last_step) n_state = tsme_pkg::REM_DONE;
            tsme_pkg::REM_DONE: if (i_ack) n_state = tsme_pkg::REM_IDLE;
            default:            n_state = tsme_pkg::REM_IDLE;
        endcase
    end

    always_comb begin
        load   = (r_state == tsme_pkg::REM_IDLE) && i_start;
        run    = (r_state == tsme_pkg::REM_RUN);
        o_done = (r_state == tsme_pkg::REM_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsme_pkg::REM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        trial     = {r_rem, r_mag[MAG_W-1]};
        trial_sub = trial - {1'b0, r_len};
        rem_step  = (trial >= {1'b0, r_len}) ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mag  <= i_mag;
            r_neg  <= i_neg;
            r_len  <= i_len;
            r_rem  <= '0;
            r_step <= STEP_W'(MAG_W);
        end else if (run) begin
            r_mag  <= {r_mag[MAG_W-2:0], 1'b0};
            r_rem  <= rem_step;
            r_step <= r_step - STEP_W'(1);
        end
    end

    assign o_rem = (r_neg && (r_rem != '0)) ? (r_len - r_rem) : r_rem;

endmodule

@@ hdl/tape_stack_machine_execute_unit.sv @@
// Top level: instruction execute stage of the tape stack machine.
//
// Executes one decoded instruction per transaction and returns one result per
// transaction. Tape cells and the value stack live in synchronous RAMs; the
// read for the next instruction is issued with the state left by the current
// one and same-edge writes are bypassed, so most instructions follow each other
// back to back. Move and setptr reduce the pointer modulo the tape length in a
// bit-serial remainder unit and hold the execute stage until it is done. After
// reset the tape is swept to zero, one cell per cycle, through all TAPE_DEPTH
// cells; no instruction is accepted during the sweep, but the length register
// can be written meanwhile.
// A finished result waits in the output register while the next instruction
// executes.
module tape_stack_machine_execute_unit #(
    parameter int TAPE_DEPTH  = tsme_pkg::TAPE_DEPTH_DEF,
    parameter int STACK_DEPTH = tsme_pkg::STACK_DEPTH_DEF,
    parameter int CELL_WIDTH  = tsme_pkg::CELL_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [tsme_pkg::CFG_W-1:0]         i_cfg_wr_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [3:0]                         i_action,
    input  logic signed [tsme_pkg::ARG_W-1:0]  i_argument,
    input  logic [tsme_pkg::BYTE_W-1:0]        i_in_byte,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [tsme_pkg::PC_W-1:0]          o_next_pc,
    output logic                               o_out_valid,
    output logic [tsme_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                               o_halted,
    output logic [1:0]                         o_error_code
);

    localparam int PTR_W  = $clog2(TAPE_DEPTH);
    localparam int LEN_W  = $clog2(TAPE_DEPTH + 1);
    localparam int ST_AW  = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int SUM_W  = ((PTR_W > tsme_pkg::ARG_W) ? PTR_W : tsme_pkg::ARG_W) + 2;
    localparam int MAG_W  = SUM_W - 1;
    localparam int CMP_W  = (LEN_W > tsme_pkg::CFG_W) ? LEN_W : tsme_pkg::CFG_W;
    localparam int PC_W   = tsme_pkg::PC_W;
    localparam int ARG_W  = tsme_pkg::ARG_W;
    localparam int BYTE_W = tsme_pkg::BYTE_W;

    // architectural state
    logic [tsme_pkg::CFG_W-1:0] r_tape_length;
    logic [PTR_W-1:0]           r_ptr, n_ptr;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [PC_W-1:0]            r_pc;

    // tape clear sweep
    logic                       r_clr_active;
    logic [PTR_W-1:0]           r_clr_addr;

    // execute stage
    logic                       r_e_valid;
    tsme_pkg::t_action          r_e_action;
    logic signed [ARG_W-1:0]    r_e_arg;
    logic [BYTE_W-1:0]          r_e_in_byte;

    // output register
    logic                       r_o_valid;
    logic [PC_W-1:0]            r_o_next_pc;
    logic                       r_o_out_valid;
    logic [BYTE_W-1:0]          r_o_out_byte;
    logic                       r_o_halted;
    tsme_pkg::t_err             r_o_err;

    logic                       accept;
    logic                       e_commit;
    logic                       e_done;

    logic [CELL_WIDTH-1:0]      cur_cell;
    logic [CELL_WIDTH-1:0]      top;
    logic                       pop_empty;
    logic                       push_full;
    logic [CELL_WIDTH-1:0]      pop_val;

    logic [31:0]                arg_sx;
    logic [31:0]                arg_zx;
    logic [31:0]                add_sum;
    logic [ARG_W-1:0]           arg_u;

    logic [PC_W-1:0]            e_next_pc;
    logic                       e_jump;
    logic                       e_halt;
    tsme_pkg::t_err             e_err;
    logic                       e_out_valid;
    logic [CELL_WIDTH-1:0]      e_out_val;
    logic                       e_tape_we;
    logic [CELL_WIDTH-1:0]      e_tape_wd;
    logic                       e_push;
    logic [CELL_WIDTH-1:0]      e_push_val;
    logic                       e_pop;
    logic                       e_is_div;
    logic [CNT_W-1:0]           e_cnt_new;

    logic [CMP_W-1:0]           len_raw;
    logic [LEN_W-1:0]           eff_len;

    logic signed [SUM_W-1:0]    mv_ptr;
    logic signed [SUM_W-1:0]    mv_arg;
    logic signed [SUM_W-1:0]    mv_sum;
    logic [SUM_W-1:0]           mv_abs;
    logic [MAG_W-1:0]           div_mag;
    logic                       div_neg;
    logic                       rem_done;
    logic [LEN_W-1:0]           rem_q;

    logic                       tape_we;
    logic [PTR_W-1:0]           tape_waddr;
    logic [CELL_WIDTH-1:0]      tape_wdata;
    logic                       stk_we;
    logic [CNT_W-1:0]           stk_rd_cnt;
    logic [ST_AW-1:0]           stk_raddr;

    // ---------------------------------------------------------------- handshake
    assign o_ready  = !r_clr_active && (!r_e_valid || e_commit);
    assign accept   = i_valid && o_ready;
    assign e_done   = !e_is_div || rem_done;
    assign e_commit = r_e_valid && e_done && (!r_o_valid || i_ready);

    // ---------------------------------------------------------------- length
    always_comb begin
        len_raw = CMP_W'(r_tape_length);
        if (len_raw == '0) begin
            eff_len = LEN_W'(1);
        end else if (len_raw > CMP_W'(TAPE_DEPTH)) begin
            eff_len = LEN_W'(TAPE_DEPTH);
        end else begin
            eff_len = len_raw[LEN_W-1:0];
        end
    end

    // ---------------------------------------------------------------- execute
    assign arg_u     = $unsigned(r_e_arg);
    assign arg_sx    = 32'(r_e_arg);
    assign arg_zx    = 32'(arg_u);
    assign add_sum   = 32'(cur_cell) + arg_sx;
    assign pop_empty = (r_cnt == '0);
    assign push_full = (r_cnt == CNT_W'(STACK_DEPTH));
    assign pop_val   = pop_empty ? '0 : top;

    always_comb begin
        e_jump      = 1'b0;
        e_halt      = 1'b0;
        e_err       = tsme_pkg::ERR_NONE;
        e_out_valid = 1'b0;
        e_out_val   = '0;
        e_tape_we   = 1'b0;
        e_tape_wd   = cur_cell;
        e_push      = 1'b0;
        e_push_val  = cur_cell;
        e_pop       = 1'b0;
        e_is_div    = 1'b0;
        unique case (r_e_action)
            tsme_pkg::ACT_HALT: begin
                e_halt = 1'b1;
            end
            tsme_pkg::ACT_ADD: begin
                e_tape_we = 1'b1;
                e_tape_wd = add_sum[CELL_WIDTH-1:0];
            end
            tsme_pkg::ACT_NOP: begin
            end
            tsme_pkg::ACT_SET: begin
                e_tape_we = 1'b1;
                e_tape_wd = arg_zx[CELL_WIDTH-1:0];
            end
            tsme_pkg::ACT_POP: begin
                e_pop     = 1'b1;
                e_tape_we = 1'b1;
                e_tape_wd = pop_val;
            end
            tsme_pkg::ACT_PUSH: begin
                e_push = 1'b1;
            end
            tsme_pkg::ACT_PUSHIMM: begin
                e_push     = 1'b1;
                e_push_val = arg_sx[CELL_WIDTH-1:0];
            end
            tsme_pkg::ACT_MOVE,
            tsme_pkg::ACT_SETPTR: begin
                e_is_div = 1'b1;
            end
            tsme_pkg::ACT_JMP: begin
                e_jump = 1'b1;
            end
            tsme_pkg::ACT_JEZ: begin
                e_jump = (cur_cell == '0);
            end
            tsme_pkg::ACT_JNZ: begin
                e_jump = (cur_cell != '0);
            end
            tsme_pkg::ACT_JSEZ: begin
                e_pop  = 1'b1;
                e_jump = (pop_val == '0);
            end
            tsme_pkg::ACT_JSNZ: begin
                e_pop  = 1'b1;
                e_jump = (pop_val != '0);
            end
            tsme_pkg::ACT_IO: begin
                case (arg_u)
                    tsme_pkg::IO_IN_CELL: begin
                        e_tape_we = 1'b1;
                        e_tape_wd = CELL_WIDTH'(r_e_in_byte);
                    end
                    tsme_pkg::IO_OUT_CELL: begin
                        e_out_valid = 1'b1;
                        e_out_val   = cur_cell;
                    end
                    tsme_pkg::IO_IN_PUSH: begin
                        e_push     = 1'b1;
                        e_push_val = CELL_WIDTH'(r_e_in_byte);
                    end
                    tsme_pkg::IO_OUT_POP: begin
                        e_pop       = 1'b1;
                        e_out_valid = 1'b1;
                        e_out_val   = pop_val;
                    end
                    default: begin
                    end
                endcase
            end
            tsme_pkg::ACT_INVALID: begin
                e_halt = 1'b1;
                e_err  = tsme_pkg::ERR_INVALID;
            end
        endcase

        e_cnt_new = r_cnt;
        if (e_pop) begin
            if (pop_empty) begin
                e_err = tsme_pkg::ERR_UNDERFLOW;
            end else begin
                e_cnt_new = r_cnt - CNT_W'(1);
            end
        end
        if (e_push) begin
            if (push_full) begin
                e_err = tsme_pkg::ERR_OVERFLOW;
            end else begin
                e_cnt_new = r_cnt + CNT_W'(1);
            end
        end

        if (e_jump) begin
            e_next_pc = arg_u + PC_W'(1);
        end else if (e_halt) begin
            e_next_pc = r_pc;
        end else begin
            e_next_pc = r_pc + PC_W'(1);
        end
    end

    // ---------------------------------------------------------------- pointer reduction
    always_comb begin
        mv_ptr = SUM_W'(r_ptr);
        mv_arg = SUM_W'(r_e_arg);
        mv_sum = mv_ptr + mv_arg;
        mv_abs = mv_sum[SUM_W-1] ? $unsigned(-mv_sum) : $unsigned(mv_sum);
        if (r_e_action == tsme_pkg::ACT_MOVE) begin
            div_mag = mv_abs[MAG_W-1:0];
            div_neg = mv_sum[SUM_W-1];
        end else begin
            div_mag = MAG_W'(arg_u);
            div_neg = 1'b0;
        end
    end

    tsme_rem #(
        .MAG_W (MAG_W),
        .LEN_W (LEN_W)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_e_valid && e_is_div),
        .i_mag   (div_mag),
        .i_neg   (div_neg),
        .i_len   (eff_len),
        .i_ack   (e_commit),
        .o_done  (rem_done),
        .o_rem   (rem_q)
    );

    // ---------------------------------------------------------------- memories
    assign n_ptr = (e_commit && e_is_div) ? rem_q[PTR_W-1:0] : r_ptr;
    assign n_cnt = e_commit ? e_cnt_new : r_cnt;

    assign tape_we    = r_clr_active || (e_commit && e_tape_we);
    assign tape_waddr = r_clr_active ? r_clr_addr : r_ptr;
    assign tape_wdata = r_clr_active ? '0 : e_tape_wd;

    assign stk_we     = e_commit && e_push && !push_full;
    assign stk_rd_cnt = n_cnt - CNT_W'(1);
    assign stk_raddr  = stk_rd_cnt[ST_AW-1:0];

    tsme_ram #(
        .DEPTH (TAPE_DEPTH),
        .WIDTH (CELL_WIDTH),
        .AW    (PTR_W)
    ) u_tape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_raddr (n_ptr),
        .o_rdata (cur_cell)
    );

    tsme_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (CELL_WIDTH),
        .AW    (ST_AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (stk_we),
        .i_waddr (r_cnt[ST_AW-1:0]),
        .i_wdata (e_push_val),
        .i_raddr (stk_raddr),
        .o_rdata (top)
    );

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tape_length <= tsme_pkg::TAPE_LENGTH_RST;
            r_ptr         <= '0;
            r_cnt         <= '0;
            r_pc          <= '0;
            r_clr_active  <= 1'b1;
            r_clr_addr    <= '0;
            r_e_valid     <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tape_length <= i_cfg_wr_data;
            end
            r_ptr <= n_ptr;
            r_cnt <= n_cnt;
            if (e_commit) begin
                r_pc <= e_next_pc;
            end
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + PTR_W'(1);
                if (r_clr_addr == PTR_W'(TAPE_DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (accept) begin
                r_e_valid <= 1'b1;
            end else if (e_commit) begin
                r_e_valid <= 1'b0;
            end
            if (e_commit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e_action  <= tsme_pkg::t_action'(i_action);
            r_e_arg     <= i_argument;
            r_e_in_byte <= i_in_byte;
        end
        if (e_commit) begin
            r_o_next_pc   <= e_next_pc;
            r_o_out_valid <= e_out_valid;
            r_o_out_byte  <= e_out_val[BYTE_W-1:0];
            r_o_halted    <= e_halt;
            r_o_err       <= e_err;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_next_pc    = r_o_next_pc;
    assign o_out_valid  = r_o_out_valid;
    assign o_out_byte   = r_o_out_byte;
    assign o_halted     = r_o_halted;
    assign o_error_code = r_o_err;

    // ---------------------------------------------------------------- assertions
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_commit && e_is_div |=> LEN_W'(r_ptr) < $past(eff_len))
        else $error("reduced pointer not below tape length");

    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_commit && !e_jump && !e_halt |=> r_pc == $past(r_pc) + PC_W'(1))
        else $error("program counter did not advance by one");

    a_no_exec_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !e_commit && !r_e_valid)
        else $error("instruction executed during tape clear");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the tape stack machine execute unit.
module tb;

    localparam int PHASE_ITEMS    = 50;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 25;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PTR_W          = $clog2(tsme_pkg::TAPE_DEPTH_DEF);

    localparam int SEG_MIX   = 0;
    localparam int SEG_FLOOD = 1;
    localparam int SEG_DRAIN = 2;
    localparam int SEG_FILL  = 3;

    typedef struct packed {
        tsme_pkg::t_action                 act;
        logic signed [tsme_pkg::ARG_W-1:0] arg;
        logic [tsme_pkg::BYTE_W-1:0]       inb;
    } t_instr;

    typedef struct packed {
        logic [tsme_pkg::PC_W-1:0]   pc;
        logic                        out_valid;
        logic [tsme_pkg::BYTE_W-1:0] out_byte;
        logic                        halted;
        tsme_pkg::t_err              err;
    } t_exec_result;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_wr_en = 1'b0;
    logic [tsme_pkg::CFG_W-1:0]        i_cfg_wr_data = '0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic [3:0]                        i_action = tsme_pkg::ACT_NOP;
    logic signed [tsme_pkg::ARG_W-1:0] i_argument = '0;
    logic [tsme_pkg::BYTE_W-1:0]       i_in_byte = '0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic [tsme_pkg::PC_W-1:0]         o_next_pc;
    logic                              o_out_valid;
    logic [tsme_pkg::BYTE_W-1:0]       o_out_byte;
    logic                              o_halted;
    logic [1:0]                        o_error_code;

    // machine state mirror
    logic [tsme_pkg::BYTE_W-1:0] tape_mem [tsme_pkg::TAPE_DEPTH_DEF] = '{default: '0};
    logic [tsme_pkg::BYTE_W-1:0] stk_mem [tsme_pkg::STACK_DEPTH_DEF] = '{default: '0};
    logic [PTR_W-1:0]            ptr = '0;
    int                          stk_used = 0;
    logic [tsme_pkg::PC_W-1:0]   pc_reg = '0;
    logic [tsme_pkg::CFG_W-1:0]  len_reg = tsme_pkg::TAPE_LENGTH_RST;

    t_instr       program_queue [$];
    t_exec_result retire_queue [$];
    t_instr       cur_instr;
    t_exec_result want_res;

    int unsigned send_idle_pct = 10;
    int unsigned recv_idle_pct = 47;
    bit          pressure_on = 1'b0;
    int          held_cycles = 0;
    int          idle_cycles = 0;
    int unsigned len_plan [7] = '{1, 8191, 0, 4095, 37, 4097, 2};

    int error_count = 0;
    int issued_count = 0;
    int retired_count = 0;
    int underflows = 0;
    int overflows = 0;
    int out_bytes = 0;
    int halts = 0;
    int len_settings = 0;

    tape_stack_machine_execute_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_argument    (i_argument),
        .i_in_byte     (i_in_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_next_pc     (o_next_pc),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_halted      (o_halted),
        .o_error_code  (o_error_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [tsme_pkg::BYTE_W-1:0] stack_pop(inout tsme_pkg::t_err e);
        if (stk_used == 0) begin
            e = tsme_pkg::ERR_UNDERFLOW;
            underflows++;
            return '0;
        end
        stk_used--;
        return stk_mem[stk_used];
    endfunction

    function automatic void stack_push(input logic [tsme_pkg::BYTE_W-1:0] v,
                                       inout tsme_pkg::t_err e);
        if (stk_used >= tsme_pkg::STACK_DEPTH_DEF) begin
            e = tsme_pkg::ERR_OVERFLOW;
            overflows++;
            return;
        end
        stk_mem[stk_used] = v;
        stk_used++;
    endfunction

    function automatic t_exec_result execute_instr(input t_instr it);
        t_exec_result                r;
        logic [tsme_pkg::ARG_W-1:0]  au;
        logic [tsme_pkg::PC_W-1:0]   target;
        tsme_pkg::t_err              e;
        int                          len;
        int                          p;
        au = it.arg;
        target = au + 16'd1;
        e = tsme_pkg::ERR_NONE;
        r.pc = pc_reg + 16'd1;
        r.out_valid = 1'b0;
        r.out_byte = '0;
        r.halted = 1'b0;
        if (len_reg == '0) len = 1;
        else if (len_reg > tsme_pkg::CFG_W'(tsme_pkg::TAPE_DEPTH_DEF))
            len = tsme_pkg::TAPE_DEPTH_DEF;
        else len = int'(len_reg);
        case (it.act)
            tsme_pkg::ACT_HALT: begin
                r.pc = pc_reg;
                r.halted = 1'b1;
            end
            tsme_pkg::ACT_ADD:
                tape_mem[ptr] = tape_mem[ptr] + it.arg[tsme_pkg::BYTE_W-1:0];
            tsme_pkg::ACT_NOP:     ;
            tsme_pkg::ACT_SET:     tape_mem[ptr] = au[tsme_pkg::BYTE_W-1:0];
            tsme_pkg::ACT_POP:     tape_mem[ptr] = stack_pop(e);
            tsme_pkg::ACT_PUSH:    stack_push(tape_mem[ptr], e);
            tsme_pkg::ACT_PUSHIMM: stack_push(au[tsme_pkg::BYTE_W-1:0], e);
            tsme_pkg::ACT_MOVE: begin
                p = (int'(ptr) + int'(it.arg)) % len;
                if (p < 0) p += len;
                ptr = PTR_W'(p);
            end
            tsme_pkg::ACT_SETPTR: begin
                p = int'(au) % len;
                ptr = PTR_W'(p);
            end
            tsme_pkg::ACT_JMP:  r.pc = target;
            tsme_pkg::ACT_JEZ:  if (tape_mem[ptr] == '0) r.pc = target;
            tsme_pkg::ACT_JNZ:  if (tape_mem[ptr] != '0) r.pc = target;
            tsme_pkg::ACT_JSEZ: if (stack_pop(e) == '0) r.pc = target;
            tsme_pkg::ACT_JSNZ: if (stack_pop(e) != '0) r.pc = target;
            tsme_pkg::ACT_IO: begin
                case (au)
                    tsme_pkg::IO_IN_CELL: tape_mem[ptr] = it.inb;
                    tsme_pkg::IO_OUT_CELL: begin
                        r.out_valid = 1'b1;
                        r.out_byte = tape_mem[ptr];
                    end
                    tsme_pkg::IO_IN_PUSH: stack_push(it.inb, e);
                    tsme_pkg::IO_OUT_POP: begin
                        r.out_valid = 1'b1;
                        r.out_byte = stack_pop(e);
                    end
                    default: ;
                endcase
            end
            default: begin
                r.pc = pc_reg;
                r.halted = 1'b1;
                e = tsme_pkg::ERR_INVALID;
            end
        endcase
        if (r.halted) halts++;
        if (r.out_valid) out_bytes++;
        r.err = e;
        pc_reg = r.pc;
        return r;
    endfunction

    function automatic t_instr make_instr(input tsme_pkg::t_action act,
                                          input logic [tsme_pkg::ARG_W-1:0] arg,
                                          input logic [tsme_pkg::BYTE_W-1:0] inb);
        t_instr it;
        it.act = act;
        it.arg = arg;
        it.inb = inb;
        return it;
    endfunction

    function automatic t_instr rand_instr();
        t_instr it;
        it.act = tsme_pkg::t_action'($urandom_range(15));
        case ($urandom_range(3))
            0: it.arg = tsme_pkg::ARG_W'($urandom_range(16)) - 16'd8;
            1: it.arg = tsme_pkg::ARG_W'($urandom);
            2: it.arg = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: it.arg = tsme_pkg::ARG_W'($urandom_range(300));
        endcase
        if (it.act == tsme_pkg::ACT_IO && $urandom_range(7) != 0)
            it.arg = tsme_pkg::ARG_W'($urandom_range(3));
        it.inb = tsme_pkg::BYTE_W'($urandom);
        return it;
    endfunction

    function automatic int queue_segment(input int kind);
        t_instr it;
        int     n;
        case (kind)
            SEG_FLOOD, SEG_FILL: begin
                if (kind == SEG_FILL) n = tsme_pkg::STACK_DEPTH_DEF + 4;
                else n = $urandom_range(4, 40);
                repeat (n) begin
                    it = rand_instr();
                    case ($urandom_range(2))
                        0: it.act = tsme_pkg::ACT_PUSH;
                        1: it.act = tsme_pkg::ACT_PUSHIMM;
                        default: begin
                            it.act = tsme_pkg::ACT_IO;
                            it.arg = tsme_pkg::IO_IN_PUSH;
                        end
                    endcase
                    program_queue.push_back(it);
                end
            end
            SEG_DRAIN: begin
                n = $urandom_range(4, 60);
                repeat (n) begin
                    it = rand_instr();
                    case ($urandom_range(3))
                        0: it.act = tsme_pkg::ACT_POP;
                        1: it.act = tsme_pkg::ACT_JSEZ;
                        2: it.act = tsme_pkg::ACT_JSNZ;
                        default: begin
                            it.act = tsme_pkg::ACT_IO;
                            it.arg = tsme_pkg::IO_OUT_POP;
                        end
                    endcase
                    program_queue.push_back(it);
                end
            end
            default: begin
                n = 16;
                repeat (n) program_queue.push_back(rand_instr());
            end
        endcase
        return n;
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        while (program_queue.size() != 0 || i_valid || retire_queue.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tape_length(input logic [tsme_pkg::CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        len_reg = v;
        len_settings++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                retire_queue.push_back(execute_instr(cur_instr));
                issued_count++;
            end
            if (!i_valid || o_ready) begin
                if (program_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_instr = program_queue.pop_front();
                    i_action <= cur_instr.act;
                    i_argument <= cur_instr.arg;
                    i_in_byte <= cur_instr.inb;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                retired_count++;
                if (retire_queue.size() == 0) begin
                    report_error("result transaction with no instruction outstanding");
                end else begin
                    want_res = retire_queue.pop_front();
                    if (o_next_pc !== want_res.pc)
                        report_error($sformatf("next_pc %h, want %h", o_next_pc, want_res.pc));
                    if (o_out_valid !== want_res.out_valid)
                        report_error($sformatf("out_valid %b, want %b",
                                               o_out_valid, want_res.out_valid));
                    if (o_out_byte !== want_res.out_byte)
                        report_error($sformatf("out_byte %h, want %h",
                                               o_out_byte, want_res.out_byte));
                    if (o_halted !== want_res.halted)
                        report_error($sformatf("halted %b, want %b", o_halted, want_res.halted));
                    if (o_error_code !== want_res.err)
                        report_error($sformatf("error_code %0d, want %0d",
                                               o_error_code, want_res.err));
                end
            end
            if (pressure_on && held_cycles < HOLD_CYCLES) begin
                held_cycles <= held_cycles + 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int queued;
        int k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        len_plan[6] = $urandom_range(2, 4094);

        program_queue.push_back(make_instr(tsme_pkg::ACT_ADD, 16'h7FFF, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_ADD, 16'h8000, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_JEZ, 16'hFFFF, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_JNZ, 16'hFFFF, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_SET, 16'hFF00, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_JEZ, 16'h7FFF, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_POP, 16'h0000, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_JSEZ, 16'h0064, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_JSNZ, 16'h00C8, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_IO, tsme_pkg::IO_OUT_POP, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_IO, tsme_pkg::IO_IN_CELL, 8'hFF));
        program_queue.push_back(make_instr(tsme_pkg::ACT_IO, tsme_pkg::IO_OUT_CELL, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_IO, tsme_pkg::IO_IN_PUSH, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_PUSH, 16'h0000, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_PUSHIMM, 16'h8000, 8'hFF));
        program_queue.push_back(make_instr(tsme_pkg::ACT_IO, tsme_pkg::IO_OUT_POP, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_JSNZ, 16'h1234, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_JSEZ, 16'h1234, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_IO, 16'hFFFF, 8'hFF));
        program_queue.push_back(make_instr(tsme_pkg::ACT_IO, 16'h0004, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_NOP, 16'h0000, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_HALT, 16'hFFFF, 8'hFF));
        program_queue.push_back(make_instr(tsme_pkg::ACT_INVALID, 16'h0000, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_JMP, 16'h7FFF, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_MOVE, 16'hFFFF, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_MOVE, 16'h7FFF, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_SETPTR, 16'hFFFF, 8'h00));
        program_queue.push_back(make_instr(tsme_pkg::ACT_MOVE, 16'h0001, 8'h00));
        k = program_queue.size();

        // let the directed transactions through, then stall the output side
        @(negedge i_clk);
        while (issued_count < k) @(negedge i_clk);
        pressure_on = 1'b1;

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                wait_drained();
                write_tape_length(tsme_pkg::CFG_W'(len_plan[ph-1]));
            end
            if (ph == 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 10;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queued = 0;
            if (ph % 3 == 1) queued += queue_segment(SEG_FILL);
            while (queued < PHASE_ITEMS) begin
                k = $urandom_range(9);
                if (k < 6) queued += queue_segment(SEG_MIX);
                else if (k < 8) queued += queue_segment(SEG_FLOOD);
                else queued += queue_segment(SEG_DRAIN);
            end
        end
        wait_drained();

        $display("Ran %0d instructions, %0d results checked, over %0d tape length writes.",
                 issued_count, retired_count, len_settings);
        $display("Halts/invalid %0d, byte outputs %0d, underflows %0d, overflows %0d.",
                 halts, out_bytes, underflows, overflows);
        if (error_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
